// File: rtl/lavm_pkg.sv
// Shared constants and helper functions for the look-at view matrix block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package lavm_pkg;

  // Matrix row codes, in the order they leave the block.
  localparam logic [1:0] ROW_RIGHT = 2'd0;
  localparam logic [1:0] ROW_UP    = 2'd1;
  localparam logic [1:0] ROW_FWD   = 2'd2;
  localparam logic [1:0] ROW_LAST  = 2'd3;

  localparam int NORM_BITS = 30;  // normalised magnitudes lie in [2^29, 2^30)
  localparam int SQRT_STEPS = 32; // root digits of a 64-bit radicand
  localparam int SQRT_STAGES = SQRT_STEPS / 2;

  // Bit length of a 64-bit word, 0 for zero.
  function automatic logic [6:0] bit_len(input logic [63:0] x);
    logic [6:0] n;
    n = 7'd0;
    for (int i = 0; i < 64; i++) begin
      if (x[i]) n = 7'(i + 1);
    end
    return n;
  endfunction

  // Round half away from zero by sh fraction bits, then saturate to 32 bits.
  function automatic logic signed [31:0] rnd_sat(input logic signed [65:0] v, input int sh);
    logic [65:0] m;
    logic [65:0] r;
    logic signed [66:0] s;
    m = v[65] ? 66'(-v) : 66'(v);
    r = (m + (66'd1 << (sh - 1))) >> sh;
    s = v[65] ? -$signed({1'b0, r}) : $signed({1'b0, r});
    if (s > 67'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (s < -67'sd2147483648) begin
      return 32'sh80000000;
    end
    return s[31:0];
  endfunction

endpackage

// File: rtl/lavm_norm3.sv
// Pipelined 3-vector normaliser: pre-shift, sum of squares, 2-digit-per-stage square
// root and 2-bit-per-stage restoring division per lane. Depends on lavm_pkg.
`timescale 1ns / 1ps

module lavm_norm3 import lavm_pkg::*; #(
  parameter int FRAC_BITS = 16,
  parameter int SB_W      = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic signed [2:0][63:0] vec_i,
  input  logic [SB_W-1:0]         sb_i,
  output logic                    valid_o,
  output logic signed [2:0][31:0] unit_o,
  output logic                    ok_o,
  output logic [SB_W-1:0]         sb_o
);

  localparam int DIV_D  = FRAC_BITS + 1;
  localparam int DIV_ST = (DIV_D + 1) / 2;
  localparam int NW     = NORM_BITS + 1 + FRAC_BITS;
  localparam int MW     = 3 * NORM_BITS;
  localparam int CW     = SB_W + 4 + MW;
  localparam int DCW    = SB_W + 4;

  // Stage A: magnitudes and common bit length
  logic               a_v_q;
  logic [2:0][63:0]   a_mag_q;
  logic [2:0]         a_neg_q;
  logic [6:0]         a_len_q;
  logic [SB_W-1:0]    a_sb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (en_i) begin
      a_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        a_mag_q[i] <= vec_i[i][63] ? 64'(-vec_i[i]) : 64'(vec_i[i]);
        a_neg_q[i] <= vec_i[i][63];
      end
      a_len_q <= bit_len((vec_i[0][63] ? 64'(-vec_i[0]) : 64'(vec_i[0])) |
                         (vec_i[1][63] ? 64'(-vec_i[1]) : 64'(vec_i[1])) |
                         (vec_i[2][63] ? 64'(-vec_i[2]) : 64'(vec_i[2])));
      a_sb_q  <= sb_i;
    end
  end

  // Stage B: shift so the largest magnitude lands in [2^29, 2^30)
  logic                          b_v_q;
  logic [2:0][NORM_BITS-1:0]     b_m_q;
  logic [2:0]                    b_neg_q;
  logic                          b_zero_q;
  logic [SB_W-1:0]               b_sb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else if (en_i) begin
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        if (a_len_q > 7'(NORM_BITS)) begin
          b_m_q[i] <= NORM_BITS'(a_mag_q[i] >> (a_len_q - 7'(NORM_BITS)));
        end else begin
          b_m_q[i] <= NORM_BITS'(a_mag_q[i] << (7'(NORM_BITS) - a_len_q));
        end
      end
      b_neg_q  <= a_neg_q;
      b_zero_q <= (a_len_q == 7'd0);
      b_sb_q   <= a_sb_q;
    end
  end

  // Stage C: squares
  logic                          c_v_q;
  logic [2:0][2*NORM_BITS-1:0]   c_sq_q;
  logic [CW-1:0]                 c_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
    end else if (en_i) begin
      c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        c_sq_q[i] <= b_m_q[i] * b_m_q[i];
      end
      c_c_q <= {b_sb_q, b_zero_q, b_neg_q, b_m_q};
    end
  end

  // Square root pipeline; index 0 holds the sum of squares
  logic            sq_v_q [0:SQRT_STAGES];
  logic [63:0]     sq_n_q [0:SQRT_STAGES];
  logic [63:0]     sq_r_q [0:SQRT_STAGES];
  logic [CW-1:0]   sq_c_q [0:SQRT_STAGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q[0] <= 1'b0;
    end else if (en_i) begin
      sq_v_q[0] <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_n_q[0] <= 64'(c_sq_q[0]) + 64'(c_sq_q[1]) + 64'(c_sq_q[2]);
      sq_r_q[0] <= 64'd0;
      sq_c_q[0] <= c_c_q;
    end
  end

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
    logic [63:0] n_d;
    logic [63:0] r_d;

    always_comb begin
      logic [63:0] bt;
      n_d = sq_n_q[k];
      r_d = sq_r_q[k];
      for (int t = 0; t < 2; t++) begin
        bt = 64'd1 << (62 - 2 * (2 * k + t));
        if (n_d >= r_d + bt) begin
          n_d = n_d - (r_d + bt);
          r_d = (r_d >> 1) + bt;
        end else begin
          r_d = r_d >> 1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        sq_v_q[k+1] <= sq_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_n_q[k+1] <= n_d;
        sq_r_q[k+1] <= r_d;
        sq_c_q[k+1] <= sq_c_q[k];
      end
    end
  end

  // Division pipeline; index 0 is the set-up stage
  logic                    dv_v_q   [0:DIV_ST];
  logic [2:0][32:0]        dv_r_q   [0:DIV_ST];
  logic [2:0][FRAC_BITS:0] dv_n_q   [0:DIV_ST];
  logic [2:0][FRAC_BITS:0] dv_q_q   [0:DIV_ST];
  logic [31:0]             dv_len_q [0:DIV_ST];
  logic [DCW-1:0]          dv_c_q   [0:DIV_ST];

  logic [31:0]             su_len;
  logic [CW-1:0]           su_c;
  logic [2:0][NW-1:0]      su_num;

  always_comb begin
    su_len = sq_r_q[SQRT_STAGES][31:0];
    su_c   = sq_c_q[SQRT_STAGES];
    for (int i = 0; i < 3; i++) begin
      su_num[i] = (NW'(su_c[i*NORM_BITS +: NORM_BITS]) << FRAC_BITS) + NW'(su_len >> 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q[0] <= 1'b0;
    end else if (en_i) begin
      dv_v_q[0] <= sq_v_q[SQRT_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        dv_r_q[0][i] <= 33'(su_num[i] >> (FRAC_BITS + 1));
        dv_n_q[0][i] <= su_num[i][FRAC_BITS:0];
        dv_q_q[0][i] <= '0;
      end
      dv_len_q[0] <= su_len;
      dv_c_q[0]   <= su_c[CW-1:MW];
    end
  end

  for (genvar k = 0; k < DIV_ST; k++) begin : g_div
    logic [2:0][32:0]        r_d;
    logic [2:0][FRAC_BITS:0] n_d;
    logic [2:0][FRAC_BITS:0] q_d;

    always_comb begin
      logic [32:0] rr;
      r_d = dv_r_q[k];
      n_d = dv_n_q[k];
      q_d = dv_q_q[k];
      for (int i = 0; i < 3; i++) begin
        for (int t = 0; t < 2; t++) begin
          if (2 * k + t < DIV_D) begin
            rr = {r_d[i][31:0], n_d[i][FRAC_BITS]};
            n_d[i] = n_d[i] << 1;
            if (rr >= 33'(dv_len_q[k])) begin
              rr = rr - 33'(dv_len_q[k]);
              q_d[i] = {q_d[i][FRAC_BITS-1:0], 1'b1};
            end else begin
              q_d[i] = {q_d[i][FRAC_BITS-1:0], 1'b0};
            end
            r_d[i] = rr;
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        dv_v_q[k+1] <= dv_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_r_q[k+1]   <= r_d;
        dv_n_q[k+1]   <= n_d;
        dv_q_q[k+1]   <= q_d;
        dv_len_q[k+1] <= dv_len_q[k];
        dv_c_q[k+1]   <= dv_c_q[k];
      end
    end
  end

  // Restore signs; a zero vector gives zero and drops ok
  logic [DCW-1:0] fin_c;

  always_comb begin
    fin_c   = dv_c_q[DIV_ST];
    valid_o = dv_v_q[DIV_ST];
    ok_o    = !fin_c[3];
    sb_o    = fin_c[DCW-1:4];
    for (int i = 0; i < 3; i++) begin
      if (fin_c[3]) begin
        unit_o[i] = '0;
      end else if (fin_c[i]) begin
        unit_o[i] = -$signed(32'(dv_q_q[DIV_ST][i]));
      end else begin
        unit_o[i] = $signed(32'(dv_q_q[DIV_ST][i]));
      end
    end
  end

endmodule

// File: rtl/look_at_view_matrix.sv
// Values are Q16.16 at FRAC_BITS = 16. A new item enters only while the row buffer is empty
// or its last row is leaving, as the four rows leave on one output port; each pipeline
// stage can take an item every cycle, and a stall freezes the whole pipe.
// Reset: asynchronous, active low; clears valid bits and the row buffer, no clearing pass.
// Holds the top level: input register, two normalisers, cross and dot stages, row buffer.
// Depends on lavm_pkg and lavm_norm3.
`timescale 1ns / 1ps

module look_at_view_matrix import lavm_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] eye_x_i,
  input  logic signed [31:0] eye_y_i,
  input  logic signed [31:0] eye_z_i,
  input  logic signed [31:0] aim_x_i,
  input  logic signed [31:0] aim_y_i,
  input  logic signed [31:0] aim_z_i,
  input  logic signed [31:0] up_hint_x_i,
  input  logic signed [31:0] up_hint_y_i,
  input  logic signed [31:0] up_hint_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         row_number_o,
  output logic signed [31:0] col0_o,
  output logic signed [31:0] col1_o,
  output logic signed [31:0] col2_o,
  output logic signed [31:0] col3_o,
  output logic               last_row_o,
  output logic               degenerate_o
);

  localparam int SBA_W = 192;
  localparam int SBB_W = 193;

  logic en;
  logic full_q;
  logic [1:0] row_q;
  logic drain;

  assign drain      = full_q && !out_stall_i && (row_q == ROW_LAST);
  assign en         = !full_q || drain;
  assign in_stall_o = !en;

  // Input register
  logic                    i_v_q;
  logic signed [2:0][31:0] i_eye_q, i_aim_q, i_up_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_v_q <= 1'b0;
    end else if (en) begin
      i_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      i_eye_q <= {eye_z_i, eye_y_i, eye_x_i};
      i_aim_q <= {aim_z_i, aim_y_i, aim_x_i};
      i_up_q  <= {up_hint_z_i, up_hint_y_i, up_hint_x_i};
    end
  end

  // Forward vector
  logic signed [2:0][63:0] dir;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dir[i] = 64'($signed(i_aim_q[i])) - 64'($signed(i_eye_q[i]));
    end
  end

  logic                    na_v;
  logic signed [2:0][31:0] na_f;
  logic                    na_ok;
  logic [SBA_W-1:0]        na_sb;

  lavm_norm3 #(.FRAC_BITS(FRAC_BITS), .SB_W(SBA_W)) u_norm_fwd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (i_v_q),
    .vec_i   (dir),
    .sb_i    ({i_up_q, i_eye_q}),
    .valid_o (na_v),
    .unit_o  (na_f),
    .ok_o    (na_ok),
    .sb_o    (na_sb)
  );

  // Cross f x up: products, then differences
  logic                    x1_v_q;
  logic signed [5:0][63:0] x1_p_q;
  logic signed [2:0][31:0] x1_f_q, x1_eye_q;
  logic                    x1_ok_q;
  logic signed [2:0][31:0] na_up, na_eye;

  assign na_eye = na_sb[95:0];
  assign na_up  = na_sb[191:96];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_v_q <= 1'b0;
    end else if (en) begin
      x1_v_q <= na_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_p_q[0] <= $signed(na_f[1]) * $signed(na_up[2]);
      x1_p_q[1] <= $signed(na_f[2]) * $signed(na_up[1]);
      x1_p_q[2] <= $signed(na_f[2]) * $signed(na_up[0]);
      x1_p_q[3] <= $signed(na_f[0]) * $signed(na_up[2]);
      x1_p_q[4] <= $signed(na_f[0]) * $signed(na_up[1]);
      x1_p_q[5] <= $signed(na_f[1]) * $signed(na_up[0]);
      x1_f_q    <= na_f;
      x1_eye_q  <= na_eye;
      x1_ok_q   <= na_ok;
    end
  end

  logic                    x2_v_q;
  logic signed [2:0][63:0] x2_c_q;
  logic signed [2:0][31:0] x2_f_q, x2_eye_q;
  logic                    x2_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x2_v_q <= 1'b0;
    end else if (en) begin
      x2_v_q <= x1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x2_c_q[0] <= x1_p_q[0] - x1_p_q[1];
      x2_c_q[1] <= x1_p_q[2] - x1_p_q[3];
      x2_c_q[2] <= x1_p_q[4] - x1_p_q[5];
      x2_f_q    <= x1_f_q;
      x2_eye_q  <= x1_eye_q;
      x2_ok_q   <= x1_ok_q;
    end
  end

  // Right vector
  logic                    nb_v;
  logic signed [2:0][31:0] nb_s;
  logic                    nb_ok;
  logic [SBB_W-1:0]        nb_sb;

  lavm_norm3 #(.FRAC_BITS(FRAC_BITS), .SB_W(SBB_W)) u_norm_right (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (x2_v_q),
    .vec_i   (x2_c_q),
    .sb_i    ({x2_ok_q, x2_eye_q, x2_f_q}),
    .valid_o (nb_v),
    .unit_o  (nb_s),
    .ok_o    (nb_ok),
    .sb_o    (nb_sb)
  );

  logic signed [2:0][31:0] nb_f, nb_eye;
  assign nb_f   = nb_sb[95:0];
  assign nb_eye = nb_sb[191:96];

  // P1: s x f products and dot products with the eye
  logic                    p1_v_q;
  logic signed [5:0][63:0] p1_sf_q;
  logic signed [2:0][63:0] p1_se_q, p1_fe_q;
  logic signed [2:0][31:0] p1_s_q, p1_f_q, p1_eye_q;
  logic                    p1_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
    end else if (en) begin
      p1_v_q <= nb_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_sf_q[0] <= $signed(nb_s[1]) * $signed(nb_f[2]);
      p1_sf_q[1] <= $signed(nb_s[2]) * $signed(nb_f[1]);
      p1_sf_q[2] <= $signed(nb_s[2]) * $signed(nb_f[0]);
      p1_sf_q[3] <= $signed(nb_s[0]) * $signed(nb_f[2]);
      p1_sf_q[4] <= $signed(nb_s[0]) * $signed(nb_f[1]);
      p1_sf_q[5] <= $signed(nb_s[1]) * $signed(nb_f[0]);
      for (int i = 0; i < 3; i++) begin
        p1_se_q[i] <= $signed(nb_s[i]) * $signed(nb_eye[i]);
        p1_fe_q[i] <= $signed(nb_f[i]) * $signed(nb_eye[i]);
      end
      p1_s_q   <= nb_s;
      p1_f_q   <= nb_f;
      p1_eye_q <= nb_eye;
      p1_ok_q  <= nb_ok && nb_sb[192];
    end
  end

  // P2: true up vector, right and forward translations
  logic                    p2_v_q;
  logic signed [2:0][31:0] p2_u_q, p2_s_q, p2_f_q, p2_eye_q;
  logic signed [31:0]      p2_dsn_q, p2_df_q;
  logic                    p2_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_v_q <= 1'b0;
    end else if (en) begin
      p2_v_q <= p1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p2_u_q[0] <= rnd_sat(66'($signed(p1_sf_q[0])) - 66'($signed(p1_sf_q[1])), FRAC_BITS);
      p2_u_q[1] <= rnd_sat(66'($signed(p1_sf_q[2])) - 66'($signed(p1_sf_q[3])), FRAC_BITS);
      p2_u_q[2] <= rnd_sat(66'($signed(p1_sf_q[4])) - 66'($signed(p1_sf_q[5])), FRAC_BITS);
      p2_dsn_q  <= rnd_sat(-(66'($signed(p1_se_q[0])) + 66'($signed(p1_se_q[1])) +
                             66'($signed(p1_se_q[2]))), FRAC_BITS);
      p2_df_q   <= rnd_sat(66'($signed(p1_fe_q[0])) + 66'($signed(p1_fe_q[1])) +
                           66'($signed(p1_fe_q[2])), FRAC_BITS);
      p2_s_q    <= p1_s_q;
      p2_f_q    <= p1_f_q;
      p2_eye_q  <= p1_eye_q;
      p2_ok_q   <= p1_ok_q;
    end
  end

  // P3: u . eye products
  logic                    p3_v_q;
  logic signed [2:0][63:0] p3_ue_q;
  logic signed [2:0][31:0] p3_u_q, p3_s_q, p3_f_q;
  logic signed [31:0]      p3_dsn_q, p3_df_q;
  logic                    p3_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p3_v_q <= 1'b0;
    end else if (en) begin
      p3_v_q <= p2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p3_ue_q[i] <= $signed(p2_u_q[i]) * $signed(p2_eye_q[i]);
      end
      p3_u_q   <= p2_u_q;
      p3_s_q   <= p2_s_q;
      p3_f_q   <= p2_f_q;
      p3_dsn_q <= p2_dsn_q;
      p3_df_q  <= p2_df_q;
      p3_ok_q  <= p2_ok_q;
    end
  end

  // P4: up translation
  logic                    p4_v_q;
  logic signed [2:0][31:0] p4_u_q, p4_s_q, p4_f_q;
  logic signed [31:0]      p4_dsn_q, p4_dun_q, p4_df_q;
  logic                    p4_ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p4_v_q <= 1'b0;
    end else if (en) begin
      p4_v_q <= p3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p4_dun_q <= rnd_sat(-(66'($signed(p3_ue_q[0])) + 66'($signed(p3_ue_q[1])) +
                            66'($signed(p3_ue_q[2]))), FRAC_BITS);
      p4_u_q   <= p3_u_q;
      p4_s_q   <= p3_s_q;
      p4_f_q   <= p3_f_q;
      p4_dsn_q <= p3_dsn_q;
      p4_df_q  <= p3_df_q;
      p4_ok_q  <= p3_ok_q;
    end
  end

  // Row buffer: hold one matrix, send it a row at a time
  logic signed [2:0][31:0] m_s_q, m_u_q, m_f_q;
  logic signed [31:0]      m_dsn_q, m_dun_q, m_df_q;
  logic                    m_ok_q;
  logic                    load;

  assign load = en && p4_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
      row_q  <= ROW_RIGHT;
    end else if (load) begin
      full_q <= 1'b1;
      row_q  <= ROW_RIGHT;
    end else if (drain) begin
      full_q <= 1'b0;
    end else if (full_q && !out_stall_i) begin
      row_q <= row_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      m_s_q   <= p4_s_q;
      m_u_q   <= p4_u_q;
      m_f_q   <= p4_f_q;
      m_dsn_q <= p4_dsn_q;
      m_dun_q <= p4_dun_q;
      m_df_q  <= p4_df_q;
      m_ok_q  <= p4_ok_q;
    end
  end

  always_comb begin
    col0_o = '0;
    col1_o = '0;
    col2_o = '0;
    col3_o = '0;
    unique case (row_q)
      ROW_RIGHT: begin
        if (m_ok_q) begin
          {col2_o, col1_o, col0_o} = m_s_q;
          col3_o = m_dsn_q;
        end
      end
      ROW_UP: begin
        if (m_ok_q) begin
          {col2_o, col1_o, col0_o} = m_u_q;
          col3_o = m_dun_q;
        end
      end
      ROW_FWD: begin
        if (m_ok_q) begin
          col0_o = -m_f_q[0];
          col1_o = -m_f_q[1];
          col2_o = -m_f_q[2];
          col3_o = m_df_q;
        end
      end
      default: begin
        col3_o = 32'sd1 <<< FRAC_BITS;
      end
    endcase
  end

  assign out_valid_o  = full_q;
  assign row_number_o = row_q;
  assign last_row_o   = (row_q == ROW_LAST);
  assign degenerate_o = !m_ok_q;

  // Rows of one matrix follow each other in order
  a_row_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_row_o |=>
      out_valid_o && row_number_o == $past(row_number_o) + 2'd1)
    else $error("row sequence broken");

  // A degenerate matrix carries zeros outside the homogeneous row
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o && !last_row_o |->
      col0_o == 32'sd0 && col1_o == 32'sd0 && col2_o == 32'sd0 && col3_o == 32'sd0)
    else $error("degenerate row not zero");

  // Pipeline freezes while the buffer holds a matrix that is not leaving
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q && !drain && p4_v_q |=> p4_v_q && $stable(p4_dun_q))
    else $error("pipeline moved while row buffer was held");

endmodule

// File: dv/testbench.sv
// Self-checking testbench for look_at_view_matrix: drives camera items and checks
// every matrix row against a behavioural predictor. Depends on lavm_pkg and the RTL.
`timescale 1ns / 1ps

module testbench;
  import lavm_pkg::*;

  localparam int FRAC_BITS = 16;
  localparam int NUM_RANDOM = 170;
  localparam int LATENCY = 50 + 2 * ((FRAC_BITS + 2) / 2);
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [31:0] eye [3];
    logic signed [31:0] aim [3];
    logic signed [31:0] uph [3];
  } camera_t;

  typedef struct {
    logic [1:0]         row;
    logic signed [31:0] col [4];
    logic               last;
    logic               degen;
  } row_t;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  logic signed [31:0] eye_x, eye_y, eye_z, aim_x, aim_y, aim_z, uph_x, uph_y, uph_z;
  logic [1:0] row_number;
  logic signed [31:0] col0, col1, col2, col3;
  logic last_row, degenerate;

  camera_t pending_cams[$];
  row_t expected_rows[$];
  int errors = 0;
  longint cycles = 0;
  int send_idle_pct = 11, recv_idle_pct = 61;
  bit stim_done = 0;

  look_at_view_matrix #(.FRAC_BITS(FRAC_BITS)) uut (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_stall_o(in_stall),
    .eye_x_i(eye_x), .eye_y_i(eye_y), .eye_z_i(eye_z),
    .aim_x_i(aim_x), .aim_y_i(aim_y), .aim_z_i(aim_z),
    .up_hint_x_i(uph_x), .up_hint_y_i(uph_y), .up_hint_z_i(uph_z),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .row_number_o(row_number),
    .col0_o(col0), .col1_o(col1), .col2_o(col2), .col3_o(col3),
    .last_row_o(last_row), .degenerate_o(degenerate)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] mag(input logic signed [65:0] v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [65:0] half_away(input logic signed [65:0] v);
    logic [65:0] m;
    m = v < 0 ? -v : v;
    m = (m + (66'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return v < 0 ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [31:0] clamp32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'h7fffffff;
    if (v < -66'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Scale so the largest magnitude sits in [2^29, 2^30), then divide by the length.
  function automatic bit unit_vec(input logic signed [65:0] v [3],
                                  output logic signed [65:0] o [3]);
    logic [63:0] m [3];
    logic [63:0] top, ss, len, q;
    int nb;
    top = 0;
    ss = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = mag(v[i]);
      o[i] = 0;
      if (m[i] > top) top = m[i];
    end
    if (top == 0) return 0;
    nb = 0;
    while (nb < 64 && (top >> nb) != 0) nb++;
    for (int i = 0; i < 3; i++) begin
      m[i] = nb > 30 ? m[i] >> (nb - 30) : m[i] << (30 - nb);
      ss += m[i] * m[i];
    end
    len = int_sqrt(ss);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << FRAC_BITS) + (len >> 1)) / len;
      o[i] = v[i] < 0 ? -$signed({2'b0, q}) : $signed({2'b0, q});
    end
    return 1;
  endfunction

  task automatic predict_matrix(input camera_t c);
    logic signed [65:0] d [3], fw [3], cr [3], rt [3], up [3];
    logic signed [65:0] e [3], h [3], ds, du, df;
    row_t r;
    bit ok;
    for (int i = 0; i < 3; i++) begin
      e[i] = c.eye[i];
      h[i] = c.uph[i];
      d[i] = 66'(c.aim[i]) - e[i];
      rt[i] = 0;
      up[i] = 0;
    end
    ok = unit_vec(d, fw);
    if (ok) begin
      cr[0] = fw[1] * h[2] - fw[2] * h[1];
      cr[1] = fw[2] * h[0] - fw[0] * h[2];
      cr[2] = fw[0] * h[1] - fw[1] * h[0];
      ok = unit_vec(cr, rt);
    end
    if (ok) begin
      up[0] = clamp32(half_away(rt[1] * fw[2] - rt[2] * fw[1]));
      up[1] = clamp32(half_away(rt[2] * fw[0] - rt[0] * fw[2]));
      up[2] = clamp32(half_away(rt[0] * fw[1] - rt[1] * fw[0]));
      ds = half_away(rt[0] * e[0] + rt[1] * e[1] + rt[2] * e[2]);
      du = half_away(up[0] * e[0] + up[1] * e[1] + up[2] * e[2]);
      df = half_away(fw[0] * e[0] + fw[1] * e[1] + fw[2] * e[2]);
    end
    for (int k = 0; k < 4; k++) begin
      r.row = 2'(k);
      r.last = (k == ROW_LAST);
      r.degen = !ok;
      for (int j = 0; j < 4; j++) r.col[j] = 0;
      if (ok && k != ROW_LAST) begin
        for (int j = 0; j < 3; j++) begin
          r.col[j] = k == ROW_RIGHT ? clamp32(rt[j])
                   : k == ROW_UP ? clamp32(up[j]) : clamp32(-fw[j]);
        end
        r.col[3] = k == ROW_RIGHT ? clamp32(-ds) : k == ROW_UP ? clamp32(-du)
                 : clamp32(df);
      end
      if (k == ROW_LAST) r.col[3] = 32'sd1 << FRAC_BITS;
      expected_rows.push_back(r);
    end
  endtask

  function automatic logic signed [31:0] rand_coord(input int kind);
    case (kind)
      0: return $urandom;
      1: return $signed($urandom_range(0, 1 << 22)) - (1 << 21);
      2: return $signed($urandom_range(0, 1 << 10)) - (1 << 9);
      default: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
    endcase
  endfunction

  function automatic camera_t rand_camera();
    camera_t c;
    int kind;
    kind = $urandom_range(0, 9) < 5 ? 1 : $urandom_range(0, 3);
    for (int i = 0; i < 3; i++) begin
      c.eye[i] = rand_coord(kind);
      c.aim[i] = rand_coord(kind);
      c.uph[i] = rand_coord($urandom_range(0, 3));
    end
    case ($urandom_range(0, 15))
      0: c.aim = c.eye;                        // zero forward
      1: c.uph = '{0, 0, 0};                   // zero up hint
      2: for (int i = 0; i < 3; i++) c.uph[i] = c.aim[i] - c.eye[i];
      default: ;
    endcase
    return c;
  endfunction

  function automatic camera_t make_cam(input logic signed [31:0] ex, ey, ez,
                                       ax, ay, az, ux, uy, uz);
    camera_t c;
    c.eye = '{ex, ey, ez};
    c.aim = '{ax, ay, az};
    c.uph = '{ux, uy, uz};
    return c;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got, want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // driver
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 0;
    end else begin
      if (!in_valid || !in_stall) begin
        if (pending_cams.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          camera_t c;
          c = pending_cams.pop_front();
          predict_matrix(c);
          in_valid <= 1;
          {eye_x, eye_y, eye_z} <= {c.eye[0], c.eye[1], c.eye[2]};
          {aim_x, aim_y, aim_z} <= {c.aim[0], c.aim[1], c.aim[2]};
          {uph_x, uph_y, uph_z} <= {c.uph[0], c.uph[1], c.uph[2]};
        end else begin
          in_valid <= 0;
        end
      end
      out_stall <= $urandom_range(0, 99) < recv_idle_pct;
    end
  end

  // monitor
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_rows.size() == 0) begin
        report_mismatch("unexpected row", row_number, 0);
      end else begin
        row_t w;
        w = expected_rows.pop_front();
        if (row_number !== w.row) report_mismatch("row_number", row_number, w.row);
        if (col0 !== w.col[0]) report_mismatch("col0", col0, w.col[0]);
        if (col1 !== w.col[1]) report_mismatch("col1", col1, w.col[1]);
        if (col2 !== w.col[2]) report_mismatch("col2", col2, w.col[2]);
        if (col3 !== w.col[3]) report_mismatch("col3", col3, w.col[3]);
        if (last_row !== w.last) report_mismatch("last_row", last_row, w.last);
        if (degenerate !== w.degen) report_mismatch("degenerate", degenerate, w.degen);
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    localparam logic signed [31:0] ONE = 32'sd1 << FRAC_BITS;
    localparam logic signed [31:0] MX = 32'h7fffffff;
    localparam logic signed [31:0] MN = 32'h80000000;
    rst_n = 0;
    in_valid = 0;
    out_stall = 0;
    {eye_x, eye_y, eye_z, aim_x, aim_y, aim_z, uph_x, uph_y, uph_z} = '0;
    pending_cams.push_back(make_cam(0, 0, 0, 0, 0, -ONE, 0, ONE, 0));
    pending_cams.push_back(make_cam(ONE, 2 * ONE, 3 * ONE, 0, 0, 0, 0, ONE, 0));
    pending_cams.push_back(make_cam(5, 5, 5, 5, 5, 5, 0, ONE, 0));        // aim on eye
    pending_cams.push_back(make_cam(0, 0, 0, ONE, 0, 0, 0, 0, 0));       // no up hint
    pending_cams.push_back(make_cam(0, 0, 0, 0, ONE, 0, 0, 3 * ONE, 0)); // parallel up
    pending_cams.push_back(make_cam(MN, MN, MN, MX, MX, MX, MX, MN, MX));
    pending_cams.push_back(make_cam(MX, MX, MX, MN, MN, MN, MN, MX, MN));
    pending_cams.push_back(make_cam(MX, MN, MX, MN, MX, MN, -1, -1, -1));
    pending_cams.push_back(make_cam(MX, MX, MX, MX, MX, MX - 1, 0, MX, 0));
    pending_cams.push_back(make_cam(-1, -1, -1, 0, 0, 0, 1, 0, 0));
    pending_cams.push_back(make_cam(MN, 0, 0, MX, 1, 0, 0, 0, MN));
    pending_cams.push_back(make_cam(32'h12345678, 32'hedcba987, 32'h55555555,
                                    32'haaaaaaaa, 32'h0f0f0f0f, 32'hf0f0f0f0,
                                    32'h33333333, 32'hcccccccc, 32'h7f00ff00));
    repeat (11) @(posedge clk);
    rst_n <= 1;
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == NUM_RANDOM / 3) begin
        send_idle_pct = 61;
        recv_idle_pct = 11;
      end else if (i == 2 * NUM_RANDOM / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      pending_cams.push_back(rand_camera());
      while (pending_cams.size() > 4) @(posedge clk);
    end
    while (pending_cams.size() > 0 || in_valid) @(posedge clk);
    while (expected_rows.size() > 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
